### sv/ssp_pkg.sv
// Shared types, codes and helper functions of the sequence event stream parser.
package ssp_pkg;

	// Status bytes of the stream
	localparam logic [7:0] ST_DELTA   = 8'h88;
	localparam logic [7:0] ST_NOTE    = 8'h90;
	localparam logic [7:0] ST_NOTE_V  = 8'h98;
	localparam logic [7:0] ST_POLY    = 8'hA0;
	localparam logic [7:0] ST_BAR     = 8'hA8;
	localparam logic [7:0] ST_CTRL    = 8'hB0;
	localparam logic [7:0] ST_PROG    = 8'hC0;
	localparam logic [7:0] ST_CPRES   = 8'hD0;
	localparam logic [7:0] ST_BEND    = 8'hE0;
	localparam logic [7:0] ST_TRKSEL  = 8'hE8;
	localparam logic [7:0] ST_PAYLOAD = 8'hF0;
	localparam logic [7:0] ST_PREFIX  = 8'hFF;

	// Event kinds on the result channel
	localparam logic [3:0] KIND_TIMESIG = 4'd0;
	localparam logic [3:0] KIND_POLY    = 4'd1;
	localparam logic [3:0] KIND_CTRL    = 4'd2;
	localparam logic [3:0] KIND_PROG    = 4'd3;
	localparam logic [3:0] KIND_CPRES   = 4'd4;
	localparam logic [3:0] KIND_BEND    = 4'd5;
	localparam logic [3:0] KIND_MIXER   = 4'd6;
	localparam logic [3:0] KIND_SYSEX   = 4'd7;
	localparam logic [3:0] KIND_NOTE    = 4'd8;

	// Leading bytes that mark a mixer payload
	localparam logic [7:0] MIX_SIG0 = 8'd71;
	localparam logic [7:0] MIX_SIG1 = 8'd0;
	localparam logic [7:0] MIX_SIG2 = 8'd68;
	localparam logic [7:0] MIX_SIG3 = 8'd69;
	localparam logic [2:0] MIX_MIN_LEN = 3'd7;

	localparam logic signed [14:0] BEND_BIAS = 15'sd8192;

	localparam int REC_DEPTH   = 5;
	localparam int HEAD_DEPTH  = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		CL_DELTA,
		CL_BAR,
		CL_POLY,
		CL_CTRL,
		CL_PROG,
		CL_CPRES,
		CL_BEND,
		CL_TRKSEL,
		CL_NOTE,
		CL_PAYLOAD,
		CL_PREFIX,
		CL_UNKNOWN
	} rec_class_t;

	typedef enum logic [2:0] {
		PH_STATUS,
		PH_AFTER_FF,
		PH_FIXED,
		PH_SX_TRACK,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		rec_class_t cls;
	} q_item_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic stopped;
		logic fire;
	} back_stat_t;

	function automatic rec_class_t classify(input logic [7:0] b);
		rec_class_t c;
		case (b)
			ST_DELTA:   c = CL_DELTA;
			ST_NOTE:    c = CL_NOTE;
			ST_NOTE_V:  c = CL_NOTE;
			ST_POLY:    c = CL_POLY;
			ST_BAR:     c = CL_BAR;
			ST_CTRL:    c = CL_CTRL;
			ST_PROG:    c = CL_PROG;
			ST_CPRES:   c = CL_CPRES;
			ST_BEND:    c = CL_BEND;
			ST_TRKSEL:  c = CL_TRKSEL;
			ST_PAYLOAD: c = CL_PAYLOAD;
			ST_PREFIX:  c = CL_PREFIX;
			default:    c = CL_UNKNOWN;
		endcase
		return c;
	endfunction

	// Bytes that follow the status in a fixed-length record
	function automatic logic [2:0] fixed_len(input rec_class_t c);
		logic [2:0] n;
		case (c)
			CL_DELTA:  n = 3'd2;
			CL_BAR:    n = 3'd4;
			CL_POLY:   n = 3'd3;
			CL_CTRL:   n = 3'd3;
			CL_BEND:   n = 3'd3;
			CL_PROG:   n = 3'd2;
			CL_CPRES:  n = 3'd2;
			CL_TRKSEL: n = 3'd1;
			default:   n = 3'd6;
		endcase
		return n;
	endfunction

endpackage

### sv/sequence_event_stream_parser.sv
// Sequence event stream parser: one byte per cycle in (stalled while the queue is full), decoded events out.
// Throughput: one byte per cycle sustained while the queue has room; a four-entry queue parts input and parser.
// A byte accepted into the queue is parsed when the parser pops it; the event that it
// completes is loaded into the output register and held there until it is taken.
// Reset clears the phase machine, tick, stop flag, queue pointers and output valid;
// the record and payload byte stores are not cleared and need no clearing pass.
module sequence_event_stream_parser
	import ssp_pkg::*;
#(
	parameter int TRACK_COUNT_P = 64
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               stream_valid,
	output logic               stream_stall,
	input  logic [7:0]         stream_byte,
	input  logic               stream_end,
	output logic               event_valid,
	input  logic               event_stall,
	output logic [3:0]         event_kind,
	output logic [5:0]         track_index,
	output logic [31:0]        event_tick,
	output logic signed [14:0] first_value,
	output logic [7:0]         second_value,
	output logic [7:0]         third_value,
	output logic [13:0]        note_duration,
	output logic [7:0]         variation_kind
);

	q_stat_t    q_stat;
	q_item_t    push_item;
	q_item_t    pop_item;
	logic       push;
	logic       pop;
	back_stat_t bstat;

	ssp_front u_front (
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream_byte  (stream_byte),
		.stream_end   (stream_end),
		.q_stat       (q_stat),
		.push         (push),
		.push_item    (push_item)
	);

	ssp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	ssp_back #(
		.TRACK_COUNT_P (TRACK_COUNT_P)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_stat         (q_stat),
		.pop_item       (pop_item),
		.pop            (pop),
		.event_valid    (event_valid),
		.event_stall    (event_stall),
		.event_kind     (event_kind),
		.track_index    (track_index),
		.event_tick     (event_tick),
		.first_value    (first_value),
		.second_value   (second_value),
		.third_value    (third_value),
		.note_duration  (note_duration),
		.variation_kind (variation_kind),
		.bstat          (bstat)
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("parser took an item from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.stopped |=> bstat.stopped)
		else $error("stop flag cleared without reset");

	a_no_fire_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.stopped |-> !bstat.fire)
		else $error("event decoded after the stream stopped");

	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.fire |=> event_valid)
		else $error("decoded event not presented");

endmodule

### sv/ssp_front.sv
// Input side: takes stream bytes, tags each with its record class and pushes it on the queue.
module ssp_front
	import ssp_pkg::*;
(
	input  logic       stream_valid,
	output logic       stream_stall,
	input  logic [7:0] stream_byte,
	input  logic       stream_end,
	input  q_stat_t    q_stat,
	output logic       push,
	output q_item_t    push_item
);

	assign stream_stall = q_stat.full;
	assign push         = stream_valid && !q_stat.full;

	always_comb begin
		push_item.data = stream_byte;
		push_item.last = stream_end;
		push_item.cls  = classify(stream_byte);
	end

endmodule

### sv/ssp_queue.sv
// Short queue of classified items between the input side and the parser.
module ssp_queue
	import ssp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	input  logic    pop,
	output q_item_t pop_item,
	output q_stat_t q_stat
);

	q_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	assign pop_item     = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign q_stat.count = count_q;

endmodule

### sv/ssp_back.sv
// Parser: runs the record phase machine, keeps the tick and registers decoded events.
module ssp_back
	import ssp_pkg::*;
#(
	parameter int TRACK_COUNT_P = 64
)(
	input  logic               clk,
	input  logic               arst_n,
	input  q_stat_t            q_stat,
	input  q_item_t            pop_item,
	output logic               pop,
	output logic               event_valid,
	input  logic               event_stall,
	output logic [3:0]         event_kind,
	output logic [5:0]         track_index,
	output logic [31:0]        event_tick,
	output logic signed [14:0] first_value,
	output logic [7:0]         second_value,
	output logic [7:0]         third_value,
	output logic [13:0]        note_duration,
	output logic [7:0]         variation_kind,
	output back_stat_t         bstat
);

	localparam logic [8:0] TRACK_MAX = 9'(TRACK_COUNT_P - 1);

	function automatic logic [5:0] track_of(input logic [7:0] raw);
		logic [8:0] t;
		t = (raw == 8'd0) ? 9'd0 : {1'b0, raw} - 9'd1;
		if (t > TRACK_MAX)
			t = TRACK_MAX;
		return t[5:0];
	endfunction

	phase_t     phase_q, phase_d;
	rec_class_t cls_q, cls_d;
	logic [2:0] cnt_q, cnt_d;
	logic [31:0] tick_q, tick_d;
	logic       stop_q, stop_d;

	logic [7:0] rec_q  [REC_DEPTH];
	logic [7:0] head_q [HEAD_DEPTH];
	logic [7:0] head_v [HEAD_DEPTH];

	logic       rec_we, head_we;
	logic [2:0] rec_idx, head_idx;
	logic [2:0] pcnt_v;
	logic       fire, fire_payload;

	logic       ts_start, ts_stop;
	phase_t     ts_phase;

	logic [3:0]         ev_kind;
	logic [5:0]         ev_track;
	logic signed [14:0] ev_first;
	logic [7:0]         ev_second, ev_third, ev_var;
	logic [13:0]        ev_dur;
	logic [13:0]        bar_num;

	logic               out_valid_q;
	logic [3:0]         kind_q;
	logic [5:0]         track_q;
	logic [31:0]        tick_out_q;
	logic signed [14:0] first_q;
	logic [7:0]         second_q, third_q, var_q;
	logic [13:0]        dur_q;

	q_item_t it;
	assign it = pop_item;

	// Take the next item whenever the output register is free or draining
	assign pop = !q_stat.empty && (!out_valid_q || !event_stall);

	// What a byte does when it sits where a status is expected
	always_comb begin
		ts_start = 1'b0;
		ts_stop  = 1'b0;
		ts_phase = PH_STATUS;
		case (it.cls)
			CL_PREFIX:  ts_phase = PH_AFTER_FF;
			CL_UNKNOWN: ts_stop  = 1'b1;
			CL_PAYLOAD: begin
				ts_start = 1'b1;
				ts_phase = PH_SX_TRACK;
			end
			default: begin
				ts_start = 1'b1;
				ts_phase = PH_FIXED;
			end
		endcase
	end

	assign bar_num = {rec_q[1][6:0], rec_q[0][6:0]};

	always_comb begin
		phase_d      = phase_q;
		cls_d        = cls_q;
		cnt_d        = cnt_q;
		tick_d       = tick_q;
		stop_d       = stop_q;
		rec_we       = 1'b0;
		rec_idx      = cnt_q;
		head_we      = 1'b0;
		head_idx     = cnt_q;
		pcnt_v       = cnt_q;
		fire         = 1'b0;
		fire_payload = 1'b0;
		ev_kind      = KIND_TIMESIG;
		ev_track     = '0;
		ev_first     = '0;
		ev_second    = '0;
		ev_third     = '0;
		ev_dur       = '0;
		ev_var       = '0;

		if (pop && !stop_q) begin
			case (phase_q)
				PH_STATUS: begin
					phase_d = ts_phase;
					stop_d  = ts_stop;
					if (ts_start) begin
						cls_d = it.cls;
						cnt_d = '0;
					end
				end
				PH_AFTER_FF: begin
					if (ts_start) begin
						phase_d = ts_phase;
						cls_d   = it.cls;
						cnt_d   = '0;
					end else begin
						stop_d = 1'b1;
					end
				end
				PH_FIXED: begin
					if (4'(cnt_q) + 4'd1 < 4'(fixed_len(cls_q))) begin
						rec_we = (cnt_q < 3'(REC_DEPTH));
						cnt_d  = cnt_q + 3'd1;
					end else begin
						phase_d  = PH_STATUS;
						ev_track = track_of(rec_q[0]);
						case (cls_q)
							CL_DELTA: tick_d = tick_q + {16'd0, it.data, rec_q[0]};
							CL_BAR: begin
								fire      = 1'b1;
								ev_kind   = KIND_TIMESIG;
								ev_track  = '0;
								// bar index floors at zero
								ev_first  = (bar_num == 14'd0) ? '0 :
									$signed({1'b0, bar_num - 14'd1});
								ev_second = rec_q[2];
								ev_third  = it.data;
							end
							CL_POLY: begin
								fire      = 1'b1;
								ev_kind   = KIND_POLY;
								ev_first  = $signed({7'd0, rec_q[1]});
								ev_second = it.data;
							end
							CL_CTRL: begin
								fire      = 1'b1;
								ev_kind   = KIND_CTRL;
								ev_first  = $signed({7'd0, rec_q[1]});
								ev_second = it.data;
							end
							CL_PROG: begin
								fire     = 1'b1;
								ev_kind  = KIND_PROG;
								ev_first = $signed({7'd0, it.data});
							end
							CL_CPRES: begin
								fire     = 1'b1;
								ev_kind  = KIND_CPRES;
								ev_first = $signed({7'd0, it.data});
							end
							CL_BEND: begin
								fire     = 1'b1;
								ev_kind  = KIND_BEND;
								ev_first = $signed({1'b0, it.data[6:0], rec_q[1][6:0]}) - BEND_BIAS;
							end
							CL_TRKSEL: fire = 1'b0;
							default: begin
								fire      = 1'b1;
								ev_kind   = KIND_NOTE;
								ev_first  = $signed({7'd0, rec_q[1]});
								ev_second = rec_q[2];
								ev_third  = rec_q[3];
								ev_dur    = {it.data[6:0], rec_q[4][6:0]};
								// both note statuses code the variation as zero
								ev_var    = '0;
							end
						endcase
					end
				end
				PH_SX_TRACK: begin
					rec_we  = 1'b1;
					rec_idx = '0;
					cnt_d   = '0;
					phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (it.data[7]) begin
						fire_payload = 1'b1;
						if (cnt_q == '0) begin
							// a high first byte is the whole payload
							head_we  = 1'b1;
							head_idx = '0;
							pcnt_v   = 3'd1;
							cnt_d    = 3'd1;
							phase_d  = PH_STATUS;
						end else begin
							phase_d = ts_phase;
							stop_d  = ts_stop;
							if (ts_start) begin
								cls_d = it.cls;
								cnt_d = '0;
							end
						end
					end else begin
						if (cnt_q < 3'(HEAD_DEPTH)) begin
							head_we = 1'b1;
							cnt_d   = cnt_q + 3'd1;
							pcnt_v  = cnt_q + 3'd1;
						end
						fire_payload = it.last;
					end
				end
				default: phase_d = PH_STATUS;
			endcase
			if (it.last)
				stop_d = 1'b1;
		end

		for (int i = 0; i < HEAD_DEPTH; i++)
			head_v[i] = (head_we && head_idx == 3'(i)) ? it.data : head_q[i];

		if (fire_payload && pcnt_v != '0) begin
			fire     = 1'b1;
			ev_track = track_of(rec_q[0]);
			if (pcnt_v >= MIX_MIN_LEN && head_v[0] == MIX_SIG0 && head_v[1] == MIX_SIG1
					&& head_v[2] == MIX_SIG2 && head_v[3] == MIX_SIG3) begin
				ev_kind   = KIND_MIXER;
				ev_first  = $signed({7'd0, head_v[4]}) - 15'sd1;
				ev_second = head_v[5];
				ev_third  = head_v[6];
			end else begin
				ev_kind   = KIND_SYSEX;
				ev_first  = $signed({7'd0, head_v[0]});
				ev_second = (pcnt_v > 3'd1) ? head_v[1] : 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STATUS;
			cls_q       <= CL_UNKNOWN;
			cnt_q       <= '0;
			tick_q      <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cls_q   <= cls_d;
			cnt_q   <= cnt_d;
			tick_q  <= tick_d;
			stop_q  <= stop_d;
			if (fire)
				out_valid_q <= 1'b1;
			else if (!event_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_q[rec_idx] <= it.data;
		if (head_we)
			head_q[head_idx] <= it.data;
		if (fire) begin
			kind_q     <= ev_kind;
			track_q    <= ev_track;
			tick_out_q <= tick_q;
			first_q    <= ev_first;
			second_q   <= ev_second;
			third_q    <= ev_third;
			dur_q      <= ev_dur;
			var_q      <= ev_var;
		end
	end

	assign event_valid    = out_valid_q;
	assign event_kind     = kind_q;
	assign track_index    = track_q;
	assign event_tick     = tick_out_q;
	assign first_value    = first_q;
	assign second_value   = second_q;
	assign third_value    = third_q;
	assign note_duration  = dur_q;
	assign variation_kind = var_q;

	assign bstat.stopped = stop_q;
	assign bstat.fire    = fire;

endmodule
